>>> sv/dheap_pkg.sv
`default_nettype none

package dheap_pkg;

  // Defaults for the top-level parameters
  localparam int HEAP_CAPACITY = 1024;
  localparam int HEAP_KEY_W    = 32;

  // Port widths fixed by the interface
  localparam int IN_KEY_W  = 32;
  localparam int OUT_KEY_W = 32;
  localparam int OUT_CNT_W = 11;
  localparam int ARITY_W   = 4;

  // Arity limits and reset value
  localparam logic [ARITY_W-1:0] ARITY_MIN   = 4'd2;
  localparam logic [ARITY_W-1:0] ARITY_MAX   = 4'd8;
  localparam logic [ARITY_W-1:0] ARITY_RESET = 4'd2;

  // Quotient bits resolved per divider cycle
  localparam int DIV_STEP = 8;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_ROOT,
    SQ_LAST,
    SQ_UP_DIV,
    SQ_UP_CMP,
    SQ_UP_FIN,
    SQ_DN_MUL,
    SQ_DN_SCAN,
    SQ_DN_DEC,
    SQ_DONE
  } seq_state_t;

  // One result word
  typedef struct packed {
    logic [OUT_KEY_W-1:0] min_key;
    logic [OUT_CNT_W-1:0] entry_count;
    status_t              status;
  } res_t;

  // Clamp the programmed arity to the supported range
  function automatic logic [ARITY_W-1:0] eff_arity(input logic [ARITY_W-1:0] a);
    logic [ARITY_W-1:0] r;
    r = a;
    if (a < ARITY_MIN) r = ARITY_MIN;
    else if (a > ARITY_MAX) r = ARITY_MAX;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/dary_min_heap_queue.sv
`default_nettype none

// d-ary min-heap priority queue. Each input word inserts a key (req_type 0)
// or removes the minimum (req_type 1) and yields one result word: the
// removed key, or the root key after an insert, the key count and a status
// (ok, insert refused when full, remove refused when empty). Keys sit in a
// single-port-read, single-port-write memory of CAPACITY entries; its
// contents are undefined after reset and need no clearing pass, since only
// entries below the key count are ever read. One word is worked on at a
// time and in_ready is low meanwhile. For each parent that an insert
// compares with, it gets the parent index from the divider, then reads the
// parent from memory. For each level that a remove compares, it reads the
// children from memory back to back, one read per child. Refused words,
// inserts into an empty heap and removes that empty it skip the sift. The
// number of levels is at most ceil(log_arity(count)). Results wait in an
// output register, so the next word is taken while the last result is
// still held. cfg_wr_data sets the arity (values below 2 act as 2, above 8
// as 8); write it only while the queue is idle.
module dary_min_heap_queue
  import dheap_pkg::*;
#(
  parameter int CAPACITY  = HEAP_CAPACITY,
  parameter int KEY_WIDTH = HEAP_KEY_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [ARITY_W-1:0]   cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_req_type,
  input  wire logic [IN_KEY_W-1:0]  in_key_value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [OUT_KEY_W-1:0]      out_min_key,
  output logic [OUT_CNT_W-1:0]      out_entry_count,
  output logic [1:0]                out_status
);

  logic [ARITY_W-1:0] arity_r;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_word_r;
  res_t               seq_res;
  logic               seq_res_valid, seq_res_ready;

  // Arity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arity_r <= ARITY_RESET;
    end else if (cfg_wr_en) begin
      arity_r <= cfg_wr_data;
    end
  end

  dheap_seq #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .arity     (arity_r),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req_type  (req_t'(in_req_type)),
    .req_key   (in_key_value),
    .res_valid (seq_res_valid),
    .res_ready (seq_res_ready),
    .res       (seq_res)
  );

  // Output register: free when empty or being drained
  assign seq_res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (seq_res_valid && seq_res_ready) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_res_valid && seq_res_ready) out_word_r <= seq_res;
  end

  assign out_valid       = out_valid_r;
  assign out_min_key     = out_word_r.min_key;
  assign out_entry_count = out_word_r.entry_count;
  assign out_status      = out_word_r.status;

endmodule

`default_nettype wire

>>> sv/dheap_div.sv
`default_nettype none

// Parent index divider: quotient = dividend / divisor, divisor in 2..8.
// Resolves DIV_STEP quotient bits per cycle, MSB first.
module dheap_div
  import dheap_pkg::*;
#(
  parameter int IDX_W = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [IDX_W-1:0]   dividend,
  input  wire logic [ARITY_W-1:0] divisor,
  output logic                    done,
  output logic [IDX_W-1:0]        quotient
);

  localparam int NCYC  = (IDX_W + DIV_STEP - 1) / DIV_STEP;
  localparam int PAD_W = NCYC * DIV_STEP;
  localparam int CYC_W = (NCYC > 1) ? $clog2(NCYC) : 1;

  logic [PAD_W-1:0]   num_r, num_nxt;
  logic [ARITY_W-1:0] rem_r, rem_nxt;
  logic [ARITY_W-1:0] dsr_r;
  logic [CYC_W-1:0]   cyc_r, cyc_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  // Restoring division, DIV_STEP bits per cycle
  always_comb begin
    logic [PAD_W-1:0]   n;
    logic [ARITY_W-1:0] r;
    n        = num_r;
    r        = rem_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cyc_nxt  = cyc_r;
    if (start) begin
      n        = PAD_W'(dividend);
      r        = '0;
      busy_nxt = 1'b1;
      cyc_nxt  = '0;
    end else if (busy_r) begin
      for (int i = 0; i < DIV_STEP; i++) begin
        r = {r[ARITY_W-2:0], n[PAD_W-1]};
        n = {n[PAD_W-2:0], 1'b0};
        if (r >= dsr_r) begin
          r    = r - dsr_r;
          n[0] = 1'b1;
        end
      end
      if (cyc_r == CYC_W'(NCYC - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cyc_nxt = cyc_r + 1'b1;
      end
    end
    num_nxt = n;
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cyc_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cyc_r  <= cyc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (start) dsr_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = num_r[IDX_W-1:0];

endmodule

`default_nettype wire

>>> sv/dheap_seq.sv
`default_nettype none

// Heap sequencer: key store, sift-up and sift-down control.
// The sifted key is held in a register and written once it settles.
module dheap_seq
  import dheap_pkg::*;
#(
  parameter int CAPACITY  = HEAP_CAPACITY,
  parameter int KEY_WIDTH = HEAP_KEY_W
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [ARITY_W-1:0]  arity,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire req_t                req_type,
  input  wire logic [IN_KEY_W-1:0] req_key,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output res_t                     res
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CH_W  = IDX_W + ARITY_W;

  // Key store
  logic [KEY_WIDTH-1:0] mem [CAPACITY];
  logic [KEY_WIDTH-1:0] rd_data_r;
  logic                 we, re;
  logic [IDX_W-1:0]     wa, ra;
  logic [KEY_WIDTH-1:0] wd;

  seq_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  req_t                 op_r, op_nxt;
  status_t              stat_r, stat_nxt;
  logic [ARITY_W-1:0]   d_r, d_nxt;
  logic [KEY_WIDTH-1:0] cur_r, cur_nxt;
  logic [KEY_WIDTH-1:0] root_r, root_nxt;
  logic [KEY_WIDTH-1:0] min_r, min_nxt;
  logic [KEY_WIDTH-1:0] best_r, best_nxt;
  logic                 best_vld_r, best_vld_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic [IDX_W-1:0]     par_r, par_nxt;
  logic [IDX_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [CH_W-1:0]      ch_r, ch_nxt;
  logic [CH_W-1:0]      lim_r, lim_nxt;

  logic                 div_start, div_done;
  logic [IDX_W-1:0]     div_num, div_q;
  logic [KEY_WIDTH-1:0] in_key;
  logic [CH_W-1:0]      first_ch, end_ch, cnt_ch;

  assign in_key   = KEY_WIDTH'(64'(req_key));
  assign cnt_ch   = CH_W'(cnt_r);
  assign first_ch = CH_W'(pos_r) * CH_W'(d_r) + CH_W'(1);
  assign end_ch   = first_ch + CH_W'(d_r);

  dheap_div #(
    .IDX_W (IDX_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (d_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    op_nxt       = op_r;
    stat_nxt     = stat_r;
    d_nxt        = d_r;
    cur_nxt      = cur_r;
    root_nxt     = root_r;
    min_nxt      = min_r;
    best_nxt     = best_r;
    best_vld_nxt = best_vld_r;
    best_idx_nxt = best_idx_r;
    pos_nxt      = pos_r;
    par_nxt      = par_r;
    pend_idx_nxt = pend_idx_r;
    pend_nxt     = pend_r;
    ch_nxt       = ch_r;
    lim_nxt      = lim_r;
    we           = 1'b0;
    wa           = pos_r;
    wd           = cur_r;
    re           = 1'b0;
    ra           = '0;
    div_start    = 1'b0;
    div_num      = pos_r - 1'b1;
    req_ready    = 1'b0;
    res_valid    = 1'b0;

    unique case (state_r)
      SQ_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_nxt   = req_type;
          d_nxt    = eff_arity(arity);
          stat_nxt = STAT_OK;
          if (req_type == REQ_INSERT) begin
            if (cnt_r == CNT_W'(CAPACITY)) begin
              stat_nxt  = STAT_FULL;
              re        = 1'b1;
              state_nxt = SQ_ROOT;
            end else if (cnt_r == '0) begin
              // Empty heap: the key becomes the root
              we        = 1'b1;
              wa        = '0;
              wd        = in_key;
              min_nxt   = in_key;
              cnt_nxt   = cnt_r + 1'b1;
              state_nxt = SQ_DONE;
            end else begin
              cur_nxt   = in_key;
              pos_nxt   = IDX_W'(cnt_r);
              cnt_nxt   = cnt_r + 1'b1;
              re        = 1'b1;
              state_nxt = SQ_ROOT;
            end
          end else begin
            if (cnt_r == '0) begin
              stat_nxt  = STAT_EMPTY;
              min_nxt   = '0;
              state_nxt = SQ_DONE;
            end else begin
              cnt_nxt   = cnt_r - 1'b1;
              re        = 1'b1;
              state_nxt = SQ_ROOT;
            end
          end
        end
      end

      // Root word arrives
      SQ_ROOT: begin
        if (stat_r == STAT_FULL) begin
          min_nxt   = rd_data_r;
          state_nxt = SQ_DONE;
        end else if (op_r == REQ_INSERT) begin
          root_nxt  = rd_data_r;
          div_start = 1'b1;
          state_nxt = SQ_UP_DIV;
        end else begin
          min_nxt = rd_data_r;
          if (cnt_r == '0) begin
            state_nxt = SQ_DONE;
          end else begin
            re        = 1'b1;
            ra        = IDX_W'(cnt_r);
            state_nxt = SQ_LAST;
          end
        end
      end

      // Last word becomes the sifted key, hole at the root
      SQ_LAST: begin
        cur_nxt   = rd_data_r;
        pos_nxt   = '0;
        state_nxt = SQ_DN_MUL;
      end

      SQ_UP_DIV: begin
        if (div_done) begin
          re        = 1'b1;
          ra        = div_q;
          par_nxt   = div_q;
          state_nxt = SQ_UP_CMP;
        end
      end

      // Parent larger: move it down into the hole; else write the key there
      SQ_UP_CMP: begin
        we = 1'b1;
        if (rd_data_r > cur_r) begin
          wd      = rd_data_r;
          pos_nxt = par_r;
          if (par_r == '0) begin
            state_nxt = SQ_UP_FIN;
          end else begin
            div_start = 1'b1;
            div_num   = par_r - 1'b1;
            state_nxt = SQ_UP_DIV;
          end
        end else begin
          min_nxt   = root_r;
          state_nxt = SQ_DONE;
        end
      end

      SQ_UP_FIN: begin
        we        = 1'b1;
        wa        = '0;
        min_nxt   = cur_r;
        state_nxt = SQ_DONE;
      end

      // First child index and scan limit; at a leaf, write the key
      SQ_DN_MUL: begin
        if (first_ch >= cnt_ch) begin
          we        = 1'b1;
          state_nxt = SQ_DONE;
        end else begin
          ch_nxt       = first_ch;
          lim_nxt      = (end_ch < cnt_ch) ? end_ch : cnt_ch;
          best_vld_nxt = 1'b0;
          pend_nxt     = 1'b0;
          state_nxt    = SQ_DN_SCAN;
        end
      end

      // Read children back to back, compare as data returns
      SQ_DN_SCAN: begin
        if (pend_r && (!best_vld_r || rd_data_r < best_r)) begin
          best_nxt     = rd_data_r;
          best_idx_nxt = pend_idx_r;
          best_vld_nxt = 1'b1;
        end
        if (ch_r < lim_r) begin
          re           = 1'b1;
          ra           = ch_r[IDX_W-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = ch_r[IDX_W-1:0];
          ch_nxt       = ch_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = SQ_DN_DEC;
        end
      end

      // Smallest child smaller: move it up into the hole; else write the key there
      SQ_DN_DEC: begin
        we = 1'b1;
        if (best_r < cur_r) begin
          wd        = best_r;
          pos_nxt   = best_idx_r;
          state_nxt = SQ_DN_MUL;
        end else begin
          state_nxt = SQ_DONE;
        end
      end

      SQ_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = SQ_IDLE;
      end

      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    stat_r     <= stat_nxt;
    d_r        <= d_nxt;
    cur_r      <= cur_nxt;
    root_r     <= root_nxt;
    min_r      <= min_nxt;
    best_r     <= best_nxt;
    best_vld_r <= best_vld_nxt;
    best_idx_r <= best_idx_nxt;
    pos_r      <= pos_nxt;
    par_r      <= par_nxt;
    pend_idx_r <= pend_idx_nxt;
    ch_r       <= ch_nxt;
    lim_r      <= lim_nxt;
  end

  // Key store ports: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_data_r <= mem[ra];
  end

  assign res.min_key     = OUT_KEY_W'(64'(min_r));
  assign res.entry_count = OUT_CNT_W'(cnt_r);
  assign res.status      = stat_r;

endmodule

`default_nettype wire
